[sv/calendar_month_grid_unit_defines.svh]
// Assertion macros shared by the calendar month grid unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CALENDAR_MONTH_GRID_UNIT_DEFINES_SVH
`define CALENDAR_MONTH_GRID_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CMG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar month grid assertion failed");

// Next-cycle implication, disabled during reset.
`define CMG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar month grid assertion failed");

`endif

[sv/cmg_pkg.sv]
// Package for the calendar month grid unit: constants, month tables and
// the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package cmg_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned RowW   = 3;
  localparam int unsigned ColW   = 3;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 6;
  localparam int unsigned XW     = 15;

  localparam logic [YearW-1:0]  BaseYear   = 14'd1900;
  // Leap years in 1..1899.
  localparam logic [XW-1:0]     LeapsBase  = 15'd460;
  // floor(n * Recip100 / 2^19) equals n / 100 for n below 43690.
  localparam logic [12:0]       Recip100   = 13'd5243;
  // floor(x * Recip7 / 2^18) equals x / 7 for x below 43690.
  localparam logic [15:0]       Recip7     = 16'd37450;
  localparam logic [MonthW-1:0] MonthJan   = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb   = 4'd2;
  localparam logic [MonthW-1:0] MonthDec   = 4'd12;
  localparam logic [ColW-1:0]   LastCol    = 3'd6;

  typedef struct packed {
    logic load;      // capture the accepted item
    logic mul100;    // form the reciprocal product for the division by 100
    logic sum;       // leap flag and day-count sum
    logic mul7;      // form the reciprocal product for the reduction mod 7
    logic setup;     // first weekday, month length, cell counters
    logic emit;      // load the next cell into the output register
  } cmg_cmd_t;

  typedef struct packed {
    logic month_ok;  // month code is 1..12
    logic last;      // the pending cell holds the month's final day
  } cmg_status_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the first of the month in a common year, taken mod 7.
  function automatic logic [2:0] days_before_mod7(input logic [MonthW-1:0] m);
    logic [2:0] r;
    unique case (m)
      4'd2, 4'd3, 4'd11: r = 3'd3;
      4'd4, 4'd7:        r = 3'd6;
      4'd5:              r = 3'd1;
      4'd6:              r = 3'd4;
      4'd8:              r = 3'd2;
      4'd9, 4'd12:       r = 3'd5;
      default:           r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/cmg_datapath.sv]
// Datapath of the calendar month grid unit: weekday arithmetic, cell counters
// and the output payload register. Depends on cmg_pkg.
`timescale 1ns / 1ps

module cmg_datapath (
  input  logic                          clk_i,
  input  cmg_pkg::cmg_cmd_t             cmd_i,
  output cmg_pkg::cmg_status_t          status_o,
  input  logic [cmg_pkg::YearW-1:0]     year_i,
  input  logic [cmg_pkg::MonthW-1:0]    month_i,
  output logic [cmg_pkg::RowW-1:0]      week_row_o,
  output logic [cmg_pkg::ColW-1:0]      weekday_o,
  output logic [cmg_pkg::DayW-1:0]      day_number_o,
  output logic                          last_cell_o
);
  import cmg_pkg::*;

  logic [YearW-1:0]  yr_q;
  logic [MonthW-1:0] mon_q;
  logic [26:0]       p100_q;
  logic [XW-1:0]     x_q;
  logic              leap_q;
  logic [30:0]       p7_q;
  logic [2:0]        first_q;
  logic [CountW-1:0] total_q;
  logic [CountW-1:0] k_q;
  logic [RowW-1:0]   row_q;
  logic [ColW-1:0]   col_q;
  logic [RowW-1:0]   week_row_q;
  logic [ColW-1:0]   weekday_q;
  logic [DayW-1:0]   day_q;
  logic              last_q;

  logic [YearW-1:0]  n;
  logic [7:0]        q100;
  logic [6:0]        r100;
  logic              leap;
  logic [XW-1:0]     x;
  logic [12:0]       q7;
  logic [2:0]        jan1;
  logic [3:0]        fsum;
  logic [2:0]        first;
  logic [DayW-1:0]   len;
  logic              last;
  logic [DayW-1:0]   day;

  always_comb begin
    n    = yr_q - 14'd1;
    q100 = p100_q[26:19];
    r100 = 7'(n - 14'({6'd0, q100} * 14'd100));
    // A century year gives n mod 100 = 99; it is a leap year when
    // its century count is a multiple of four.
    leap = ((yr_q[1:0] == 2'd0) && (r100 != 7'd99)) ||
           ((r100 == 7'd99) && (q100[1:0] == 2'd3));
    // 365 is 1 mod 7, so the day count reduces to years plus leap days.
    x    = {1'b0, yr_q - BaseYear} + {3'd0, n[YearW-1:2]} - {7'd0, q100}
           + {9'd0, q100[7:2]} - LeapsBase;
    q7   = p7_q[30:18];
    jan1 = 3'(x_q - 15'({2'd0, q7} * 15'd7));
    fsum = {1'b0, days_before_mod7(mon_q)} + {1'b0, jan1}
           + {3'd0, leap_q && (mon_q > MonthFeb)};
    first = (fsum >= 4'd7) ? 3'(fsum - 4'd7) : fsum[2:0];
    len  = month_len(mon_q) + {4'd0, leap_q && (mon_q == MonthFeb)};
    last = ((k_q + 6'd1) == total_q);
    day  = (k_q < {3'd0, first_q}) ? 5'd0 : 5'(k_q - {3'd0, first_q} + 6'd1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      yr_q  <= (year_i < BaseYear) ? BaseYear : year_i;
      mon_q <= month_i;
    end
    if (cmd_i.mul100) begin
      p100_q <= {13'd0, n} * {14'd0, Recip100};
    end
    if (cmd_i.sum) begin
      x_q    <= x;
      leap_q <= leap;
    end
    if (cmd_i.mul7) begin
      p7_q <= {16'd0, x_q} * {15'd0, Recip7};
    end
    if (cmd_i.setup) begin
      first_q <= first;
      total_q <= {3'd0, first} + {1'b0, len};
      k_q     <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end
    if (cmd_i.emit) begin
      week_row_q <= row_q;
      weekday_q  <= col_q;
      day_q      <= day;
      last_q     <= last;
      k_q        <= k_q + 6'd1;
      if (col_q == LastCol) begin
        col_q <= '0;
        row_q <= row_q + 3'd1;
      end else begin
        col_q <= col_q + 3'd1;
      end
    end
  end

  assign status_o.month_ok = (mon_q >= MonthJan) && (mon_q <= MonthDec);
  assign status_o.last     = last;
  assign week_row_o   = week_row_q;
  assign weekday_o    = weekday_q;
  assign day_number_o = day_q;
  assign last_cell_o  = last_q;

endmodule

[sv/cmg_ctrl.sv]
// Controller of the calendar month grid unit: sequences setup steps and the
// cell emission, and owns the output valid flag. Depends on cmg_pkg and the defines header.
`timescale 1ns / 1ps
`include "calendar_month_grid_unit_defines.svh"

module cmg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cmg_pkg::cmg_cmd_t    cmd_o,
  input  cmg_pkg::cmg_status_t status_i
);
  import cmg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SUM,
    S_MOD,
    S_FIRST,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul100 = (state_q == S_DIV);
    cmd_o.sum    = (state_q == S_SUM);
    cmd_o.mul7   = (state_q == S_MOD);
    cmd_o.setup  = (state_q == S_FIRST);
    cmd_o.emit   = (state_q == S_EMIT) && slot_free;

    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DIV;
      S_DIV:   state_d = status_i.month_ok ? S_SUM : S_IDLE;
      S_SUM:   state_d = S_MOD;
      S_MOD:   state_d = S_FIRST;
      S_FIRST: state_d = S_EMIT;
      S_EMIT:  if (cmd_o.emit && status_i.last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `CMG_ASSERT_NOW(a_emit_slot_free, cmd_o.emit, !out_valid_q || out_ready_i)
  `CMG_ASSERT_NEXT(a_last_cell_ends_item, cmd_o.emit && status_i.last, in_ready_o && out_valid_q)
  `CMG_ASSERT_NEXT(a_stall_holds_valid, out_valid_q && !out_ready_i, out_valid_q)

endmodule

[sv/calendar_month_grid_unit.sv]
// Top level of the calendar month grid unit: joins controller and datapath.
// Depends on cmg_pkg, cmg_ctrl and cmg_datapath.
`timescale 1ns / 1ps

// The unit takes one request per item on the input channel (year_i, month_i)
// and returns the month's calendar grid on the output channel, one cell per
// item in row-major order with Monday as column 0.
// Blank leading cells carry day_number_o of 0; the stream ends on the cell of
// the last day, which has last_cell_o set. Years below 1900 are treated as
// 1900. A month code outside 1..12 is taken and dropped without any cells.
// Both channels use valid/ready; an item moves when valid and ready are high.
// After an item is accepted the datapath runs four setup steps (two
// reciprocal multiplications for the divisions by 100 and by 7, the leap and
// day-count sum, and the first-weekday reduction) before the first cell is
// valid. Cells then follow one per cycle from the cell counters while the
// receiver takes them.
// A stall holds the output register and pauses the counter. in_ready_o rises
// as soon as the last cell sits in the output register, so a new request is
// accepted while that cell still waits to be taken.
// Reset clears the controller state and the output valid flag; no cell is
// pending afterwards.

module calendar_month_grid_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cmg_pkg::YearW-1:0]  year_i,
  input  logic [cmg_pkg::MonthW-1:0] month_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cmg_pkg::RowW-1:0]   week_row_o,
  output logic [cmg_pkg::ColW-1:0]   weekday_o,
  output logic [cmg_pkg::DayW-1:0]   day_number_o,
  output logic                       last_cell_o
);
  import cmg_pkg::*;

  cmg_cmd_t    cmd;
  cmg_status_t status;

  cmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  cmg_datapath u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .year_i       (year_i),
    .month_i      (month_i),
    .week_row_o   (week_row_o),
    .weekday_o    (weekday_o),
    .day_number_o (day_number_o),
    .last_cell_o  (last_cell_o)
  );

endmodule
